### sv/tre_pkg.sv
// Shared types, codes and constants of the toy RISC execute unit.
package tre_pkg;

    localparam int MEM_WORDS_DEF = 1024;
    localparam int NUM_REGS_DEF  = 8;
    localparam int DATA_W        = 32;
    localparam int DIV_STEPS     = 32;
    localparam int DIV_CNT_W     = 6;

    localparam logic [2:0] MODE_ADD   = 3'd0;
    localparam logic [2:0] MODE_ADDI  = 3'd1;
    localparam logic [2:0] MODE_NAND  = 3'd2;
    localparam logic [2:0] MODE_DIV   = 3'd3;
    localparam logic [2:0] MODE_BNE   = 3'd4;
    localparam logic [2:0] MODE_LOAD  = 3'd5;
    localparam logic [2:0] MODE_STORE = 3'd6;
    localparam logic [2:0] MODE_RSVD  = 3'd7;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_MISALIGNED = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO   = 2'd2;
    localparam logic [1:0] ST_R0_WRITE   = 2'd3;

    typedef struct packed {
        logic [2:0]         mode;
        logic [2:0]         dest_reg;
        logic [2:0]         src1_reg;
        logic [2:0]         src2_reg;
        logic signed [15:0] immediate;
    } t_instr;

    typedef struct packed {
        logic                     branch_taken;
        logic [1:0]               status;
        logic signed [DATA_W-1:0] result_value;
    } t_result;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } t_div_rsp;

endpackage

### sv/tre_stream_if.sv
// Valid/ready stream channel carrying one payload word.
interface tre_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### sv/tre_regfile.sv
// Register file: two registered read ports, one write port, reset via valid bits.
module tre_regfile #(
    parameter int NUM_REGS = tre_pkg::NUM_REGS_DEF,
    parameter int RIDX_W   = $clog2(NUM_REGS)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_rd_en,
    input  logic [RIDX_W-1:0]         i_rd_addr_a,
    input  logic [RIDX_W-1:0]         i_rd_addr_b,
    input  logic                      i_wr_en,
    input  logic [RIDX_W-1:0]         i_wr_addr,
    input  logic [tre_pkg::DATA_W-1:0] i_wr_data,
    output logic [tre_pkg::DATA_W-1:0] o_rd_data_a,
    output logic [tre_pkg::DATA_W-1:0] o_rd_data_b
);
    import tre_pkg::*;

    logic [DATA_W-1:0]   r_mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_valid;
    logic [DATA_W-1:0]   r_rd_a;
    logic [DATA_W-1:0]   r_rd_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // never-written entries read as zero
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_valid[i_rd_addr_a] ? r_mem[i_rd_addr_a] : '0;
            r_rd_b <= r_valid[i_rd_addr_b] ? r_mem[i_rd_addr_b] : '0;
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

### sv/tre_dmem.sv
// Data memory with a zero-fill sweep after reset.
module tre_dmem #(
    parameter int MEM_WORDS = tre_pkg::MEM_WORDS_DEF,
    parameter int AW        = $clog2(MEM_WORDS)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_addr,
    input  logic [tre_pkg::DATA_W-1:0] i_wdata,
    output logic [tre_pkg::DATA_W-1:0] o_rdata,
    output logic                       o_busy
);
    import tre_pkg::*;

    logic [DATA_W-1:0] r_mem [MEM_WORDS];
    logic [DATA_W-1:0] r_rdata;
    logic [AW-1:0]     r_clr_addr;
    logic              r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(MEM_WORDS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_en && i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && !i_we) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

### sv/tre_div.sv
// Radix-2 restoring divider on unsigned magnitudes, one quotient bit per cycle.
module tre_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tre_pkg::t_div_req i_req,
    output tre_pkg::t_div_rsp o_rsp
);
    import tre_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DATA_W-1:0]    r_q;
    logic [DATA_W-1:0]    r_r;
    logic [DATA_W-1:0]    r_d;
    logic [DATA_W:0]      w_trial;
    logic [DATA_W:0]      w_diff;
    logic                 w_fits;

    assign w_trial = {r_r, r_q[DATA_W-1]};
    assign w_diff  = w_trial - {1'b0, r_d};
    assign w_fits  = (w_trial >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.valid) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid) begin
            r_q <= i_req.dividend;
            r_r <= '0;
            r_d <= i_req.divisor;
        end else if (r_busy) begin
            r_q <= {r_q[DATA_W-2:0], w_fits};
            r_r <= w_fits ? w_diff[DATA_W-1:0] : w_trial[DATA_W-1:0];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

endmodule

### sv/toy_risc_execute_unit.sv
// Instruction path: accept, execute, output register; DIV waits in S_DIV for the 32-step
// radix-2 divider; LOAD and STORE pass S_ADDR and S_MEM, LOAD also S_LOAD. The word
// address is reduced modulo MEM_WORDS by compare and subtract, four steps a cycle, plus
// a final fold. Only one instruction is in flight; the next can be taken in the cycle
// after its result enters the output register. Reset zeroes the register file at once
// and clears data memory in a sweep over all MEM_WORDS words during which no word is taken.
module toy_risc_execute_unit #(
    parameter int MEM_WORDS = tre_pkg::MEM_WORDS_DEF,
    parameter int NUM_REGS  = tre_pkg::NUM_REGS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tre_stream_if.sink    i_instr,
    tre_stream_if.source  o_result
);
    import tre_pkg::*;

    localparam int RIDX_W = $clog2(NUM_REGS);
    localparam int AW     = $clog2(MEM_WORDS);

    // address reduction: magnitude below 2^(DATA_W+1), four subtract steps per cycle
    localparam int RED_W     = DATA_W + 5;
    localparam int RED_STEPS = (DATA_W + 2 - AW + 3) / 4 * 4;
    localparam int RED_CYC   = RED_STEPS / 4;
    localparam logic [RED_W-1:0] RED_D0 = RED_W'(MEM_WORDS) << (RED_STEPS - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_ADDR = 3'd3;
    localparam logic [2:0] S_MEM  = 3'd4;
    localparam logic [2:0] S_LOAD = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    function automatic logic [RIDX_W-1:0] reg_idx(input logic [2:0] f);
        logic [5:0] v;
        v = {3'b000, f};
        if (v >= 6'(NUM_REGS)) v = v - 6'(NUM_REGS);
        if (v >= 6'(NUM_REGS)) v = v - 6'(NUM_REGS);
        if (v >= 6'(NUM_REGS)) v = v - 6'(NUM_REGS);
        return v[RIDX_W-1:0];
    endfunction

    logic [2:0]        r_state, n_state;
    logic [2:0]        r_mode, n_mode;
    logic [RIDX_W-1:0] r_rd, n_rd;
    logic [15:0]       r_imm, n_imm;
    logic              r_taken, n_taken;
    logic [1:0]        r_status, n_status;
    logic [DATA_W-1:0] r_value, n_value;
    logic              r_wr_reg, n_wr_reg;
    logic              r_neg, n_neg;
    logic [AW-1:0]     r_addr, n_addr;
    logic [RED_W-1:0]  r_red_x, n_red_x;
    logic [RED_W-1:0]  r_red_d, n_red_d;
    logic [3:0]        r_red_cnt, n_red_cnt;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;

    t_instr            w_in;
    logic              w_accept;
    logic              w_out_free;
    logic [DATA_W-1:0] w_rf_a;
    logic [DATA_W-1:0] w_rf_b;
    logic              w_dmem_busy;
    logic [DATA_W-1:0] w_dmem_rdata;
    logic              w_dmem_en;
    logic              w_dmem_we;
    logic              w_rf_we;
    logic [RIDX_W-1:0] w_rd_addr_b;
    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;
    logic [DATA_W:0]   w_sum;
    logic [DATA_W:0]   w_mag;
    logic [RED_W-1:0]  w_red_x;
    logic [DATA_W-1:0] w_ma;
    logic [DATA_W-1:0] w_mb;
    logic [DATA_W-1:0] w_q;
    logic              w_writes_reg;

    assign w_in       = i_instr.payload;
    assign i_instr.ready = (r_state == S_IDLE) && !w_dmem_busy;
    assign w_accept   = i_instr.valid && i_instr.ready;
    assign w_out_free = !r_out_valid || o_result.ready;

    // bne and store compare/store R[dest] on the second read port
    assign w_rd_addr_b = (w_in.mode == MODE_BNE || w_in.mode == MODE_STORE)
                       ? reg_idx(w_in.dest_reg) : reg_idx(w_in.src2_reg);

    assign w_rf_we = (r_state == S_OUT) && w_out_free && r_wr_reg;

    tre_regfile #(
        .NUM_REGS (NUM_REGS),
        .RIDX_W   (RIDX_W)
    ) u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (w_accept),
        .i_rd_addr_a (reg_idx(w_in.src1_reg)),
        .i_rd_addr_b (w_rd_addr_b),
        .i_wr_en     (w_rf_we),
        .i_wr_addr   (r_rd),
        .i_wr_data   (r_value),
        .o_rd_data_a (w_rf_a),
        .o_rd_data_b (w_rf_b)
    );

    assign w_dmem_en = (r_state == S_MEM);
    assign w_dmem_we = (r_mode == MODE_STORE);

    tre_dmem #(
        .MEM_WORDS (MEM_WORDS),
        .AW        (AW)
    ) u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_dmem_en),
        .i_we    (w_dmem_we),
        .i_addr  (r_addr),
        .i_wdata (r_value),
        .o_rdata (w_dmem_rdata),
        .o_busy  (w_dmem_busy)
    );

    tre_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // exact signed word address before the modulo
    assign w_sum = {w_rf_a[DATA_W-1], w_rf_a} + {{19{r_imm[15]}}, r_imm[15:2]};
    assign w_mag = w_sum[DATA_W] ? (-w_sum) : w_sum;
    assign w_ma  = w_rf_a[DATA_W-1] ? (DATA_W'(0) - w_rf_a) : w_rf_a;
    assign w_mb  = w_rf_b[DATA_W-1] ? (DATA_W'(0) - w_rf_b) : w_rf_b;
    assign w_q   = w_div_rsp.quotient;

    // four compare/subtract steps against MEM_WORDS << k, k falling
    always_comb begin
        w_red_x = r_red_x;
        for (int j = 0; j < 4; j++) begin
            if (w_red_x >= (r_red_d >> j)) begin
                w_red_x = w_red_x - (r_red_d >> j);
            end
        end
    end

    assign w_writes_reg = (r_mode == MODE_ADD) || (r_mode == MODE_ADDI)
                       || (r_mode == MODE_NAND) || (r_mode == MODE_DIV)
                       || (r_mode == MODE_LOAD);

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_rd        = r_rd;
        n_imm       = r_imm;
        n_taken     = r_taken;
        n_status    = r_status;
        n_value     = r_value;
        n_wr_reg    = r_wr_reg;
        n_neg       = r_neg;
        n_addr      = r_addr;
        n_red_x     = r_red_x;
        n_red_d     = r_red_d;
        n_red_cnt   = r_red_cnt;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out       = r_out;
        w_div_req   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_mode   = w_in.mode;
                    n_rd     = reg_idx(w_in.dest_reg);
                    n_imm    = w_in.immediate;
                    n_taken  = 1'b0;
                    n_status = ST_OK;
                    n_value  = '0;
                    n_wr_reg = 1'b0;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_OUT;
                if (w_writes_reg && r_rd == '0) begin
                    n_status = ST_R0_WRITE;
                end else begin
                    unique case (r_mode)
                        MODE_ADD: begin
                            n_value  = w_rf_a + w_rf_b;
                            n_wr_reg = 1'b1;
                        end
                        MODE_ADDI: begin
                            n_value  = w_rf_a + {{16{r_imm[15]}}, r_imm};
                            n_wr_reg = 1'b1;
                        end
                        MODE_NAND: begin
                            n_value  = ~(w_rf_a & w_rf_b);
                            n_wr_reg = 1'b1;
                        end
                        MODE_DIV: begin
                            if (w_rf_b == '0) begin
                                n_status = ST_DIV_ZERO;
                            end else begin
                                w_div_req.valid    = 1'b1;
                                w_div_req.dividend = w_ma;
                                w_div_req.divisor  = w_mb;
                                n_neg   = w_rf_a[DATA_W-1] ^ w_rf_b[DATA_W-1];
                                n_state = S_DIV;
                            end
                        end
                        MODE_BNE: begin
                            n_taken = (w_rf_b != w_rf_a);
                        end
                        MODE_LOAD, MODE_STORE: begin
                            if (r_imm[1:0] != 2'b00) begin
                                n_status = ST_MISALIGNED;
                            end else begin
                                n_red_x   = RED_W'(w_mag);
                                n_red_d   = RED_D0;
                                n_red_cnt = 4'(RED_CYC);
                                n_neg     = w_sum[DATA_W];
                                n_state   = S_ADDR;
                                if (r_mode == MODE_STORE) begin
                                    n_value = w_rf_b;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_value  = r_neg ? (DATA_W'(0) - w_q) : w_q;
                    n_wr_reg = 1'b1;
                    n_state  = S_OUT;
                end
            end
            S_ADDR: begin
                if (r_red_cnt != '0) begin
                    n_red_x   = w_red_x;
                    n_red_d   = r_red_d >> 4;
                    n_red_cnt = r_red_cnt - 1'b1;
                end else begin
                    // non-negative modulo: fold a negative remainder back into range
                    if (r_neg && r_red_x != '0) begin
                        n_addr = AW'(RED_W'(MEM_WORDS) - r_red_x);
                    end else begin
                        n_addr = AW'(r_red_x);
                    end
                    n_state = S_MEM;
                end
            end
            S_MEM: begin
                n_state = (r_mode == MODE_LOAD) ? S_LOAD : S_OUT;
            end
            S_LOAD: begin
                n_value  = w_dmem_rdata;
                n_wr_reg = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.branch_taken = r_taken;
                    n_out.status       = r_status;
                    n_out.result_value = r_value;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_wr_reg    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_wr_reg    <= n_wr_reg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_rd      <= n_rd;
        r_imm     <= n_imm;
        r_taken   <= n_taken;
        r_status  <= n_status;
        r_value   <= n_value;
        r_neg     <= n_neg;
        r_addr    <= n_addr;
        r_red_x   <= n_red_x;
        r_red_d   <= n_red_d;
        r_red_cnt <= n_red_cnt;
        r_out     <= n_out;
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

endmodule
